FILE: src/rgbnv_pkg.sv
// Shared types and constants for the RGB to NV12 converter.
`default_nettype none

package rgbnv_pkg;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned LW_W = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned LINE_WIDTH_MIN = 16;
  localparam int unsigned LINE_WIDTH_RST = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STUDIO_SWING = 2'd0,
    CFG_CR_FIRST     = 2'd1,
    CFG_BLUE_FIRST   = 2'd2,
    CFG_LINE_WIDTH   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic            studio_swing;
    logic            cr_first;
    logic            blue_first;
    logic [LW_W-1:0] line_width;
  } cfg_t;

  typedef logic signed [9:0] coef_t;

  typedef struct packed {
    coef_t kr;
    coef_t kg;
    coef_t kb;
  } coef_set_t;

  localparam coef_set_t Y_FULL    = '{kr: 10'sd77,  kg: 10'sd150,  kb: 10'sd29};
  localparam coef_set_t CB_FULL   = '{kr: -10'sd43, kg: -10'sd84,  kb: 10'sd127};
  localparam coef_set_t CR_FULL   = '{kr: 10'sd127, kg: -10'sd106, kb: -10'sd21};
  localparam coef_set_t Y_STUDIO  = '{kr: 10'sd66,  kg: 10'sd129,  kb: 10'sd25};
  localparam coef_set_t CB_STUDIO = '{kr: -10'sd38, kg: -10'sd74,  kb: 10'sd112};
  localparam coef_set_t CR_STUDIO = '{kr: 10'sd112, kg: -10'sd94,  kb: -10'sd18};

  localparam logic signed [11:0] Y_OFS_FULL   = 12'sd0;
  localparam logic signed [11:0] Y_OFS_STUDIO = 12'sd16;
  localparam logic signed [11:0] C_OFS        = 12'sd128;

endpackage

`default_nettype wire

FILE: src/rgbnv_pos.sv
// Column and row parity tracker; flags pixels that carry chroma.
`default_nettype none

module rgbnv_pos #(
  parameter int unsigned MAX_LINE_WIDTH = 4096
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          adv_i,
  input  wire logic                          frame_start_i,
  input  wire logic [rgbnv_pkg::LW_W-1:0]    line_width_i,
  output logic                               chroma_valid_o
);

  localparam int unsigned CW = $clog2(MAX_LINE_WIDTH);
  localparam int unsigned WW = (rgbnv_pkg::LW_W > CW + 1) ? rgbnv_pkg::LW_W : CW + 1;

  logic [CW-1:0] col_q, col_d, col_cur;
  logic          row_odd_q, row_odd_d, row_cur;
  logic [WW-1:0] lw_ext, width_eff, col_nxt;
  logic          wrap;

  always_comb begin
    col_cur = frame_start_i ? '0 : col_q;
    row_cur = frame_start_i ? 1'b0 : row_odd_q;
    chroma_valid_o = !row_cur && !col_cur[0];

    lw_ext = WW'(line_width_i);
    if (lw_ext < WW'(rgbnv_pkg::LINE_WIDTH_MIN)) begin
      width_eff = WW'(rgbnv_pkg::LINE_WIDTH_MIN);
    end else if (lw_ext > WW'(MAX_LINE_WIDTH)) begin
      width_eff = WW'(MAX_LINE_WIDTH);
    end else begin
      width_eff = lw_ext;
    end

    col_nxt = WW'(col_cur) + WW'(1);
    wrap    = col_nxt >= width_eff;
    col_d     = wrap ? '0 : col_nxt[CW-1:0];
    row_odd_d = wrap ? !row_cur : row_cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_odd_q <= 1'b0;
    end else if (adv_i) begin
      col_q     <= col_d;
      row_odd_q <= row_odd_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/rgbnv_csc.sv
// BT.601 colour space conversion: weighted sums, rounding, offset, clamp.
`default_nettype none

module rgbnv_csc (
  input  wire logic                           studio_swing_i,
  input  wire logic                           cr_first_i,
  input  wire logic                           chroma_valid_i,
  input  wire logic [rgbnv_pkg::PIX_W-1:0]    red_i,
  input  wire logic [rgbnv_pkg::PIX_W-1:0]    green_i,
  input  wire logic [rgbnv_pkg::PIX_W-1:0]    blue_i,
  output logic      [rgbnv_pkg::PIX_W-1:0]    luma_o,
  output logic      [rgbnv_pkg::PIX_W-1:0]    chroma_first_o,
  output logic      [rgbnv_pkg::PIX_W-1:0]    chroma_second_o
);

  function automatic logic signed [19:0] wsum(
    input rgbnv_pkg::coef_set_t k,
    input logic [7:0] r,
    input logic [7:0] g,
    input logic [7:0] b
  );
    logic signed [19:0] s;
    s = k.kr * $signed({2'b00, r}) + k.kg * $signed({2'b00, g})
      + k.kb * $signed({2'b00, b});
    return s;
  endfunction

  // floor((s + 128) / 256) + ofs, clamped to a byte
  function automatic logic [7:0] scale_clamp(
    input logic signed [19:0] s,
    input logic signed [11:0] ofs
  );
    logic signed [19:0] biased;
    logic signed [11:0] v;
    logic [7:0]         res;
    biased = s + 20'sd128;
    v = $signed(biased[19:8]) + ofs;
    if (v[11]) begin
      res = '0;
    end else if (v > 12'sd255) begin
      res = 8'hFF;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  rgbnv_pkg::coef_set_t k_y, k_cb, k_cr;
  logic signed [11:0]   y_ofs;
  logic [7:0]           cb, cr;

  always_comb begin
    k_y   = studio_swing_i ? rgbnv_pkg::Y_STUDIO  : rgbnv_pkg::Y_FULL;
    k_cb  = studio_swing_i ? rgbnv_pkg::CB_STUDIO : rgbnv_pkg::CB_FULL;
    k_cr  = studio_swing_i ? rgbnv_pkg::CR_STUDIO : rgbnv_pkg::CR_FULL;
    y_ofs = studio_swing_i ? rgbnv_pkg::Y_OFS_STUDIO : rgbnv_pkg::Y_OFS_FULL;

    luma_o = scale_clamp(wsum(k_y, red_i, green_i, blue_i), y_ofs);
    cb     = scale_clamp(wsum(k_cb, red_i, green_i, blue_i), rgbnv_pkg::C_OFS);
    cr     = scale_clamp(wsum(k_cr, red_i, green_i, blue_i), rgbnv_pkg::C_OFS);

    if (chroma_valid_i) begin
      chroma_first_o  = cr_first_i ? cr : cb;
      chroma_second_o = cr_first_i ? cb : cr;
    end else begin
      chroma_first_o  = '0;
      chroma_second_o = '0;
    end
  end

endmodule

`default_nettype wire

FILE: src/rgb_to_nv12_integer_converter.sv
// Top level: RGB pixel stream to BT.601 luma and 4:2:0 interleaved chroma.
// An input beat passes through the input register, then the result register.
// Throughput: one pixel per cycle unless the output stalls; the registers form a pipeline.
// Input ready only drops while both registers hold beats and the output is stalled.
// Reset clears pipeline valids and position (column 0, even row); config returns to defaults.
`default_nettype none

module rgb_to_nv12_integer_converter #(
  parameter int unsigned MAX_LINE_WIDTH = 4096
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [rgbnv_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [rgbnv_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                                valid_i,
  output logic                                     ready_o,
  input  wire logic [rgbnv_pkg::PIX_W-1:0]         chan_a_i,
  input  wire logic [rgbnv_pkg::PIX_W-1:0]         chan_g_i,
  input  wire logic [rgbnv_pkg::PIX_W-1:0]         chan_c_i,
  input  wire logic                                frame_start_i,
  output logic                                     valid_o,
  input  wire logic                                ready_i,
  output logic      [rgbnv_pkg::PIX_W-1:0]         luma_o,
  output logic                                     chroma_valid_o,
  output logic      [rgbnv_pkg::PIX_W-1:0]         chroma_first_o,
  output logic      [rgbnv_pkg::PIX_W-1:0]         chroma_second_o
);

  rgbnv_pkg::cfg_t cfg_q;

  logic                          in_beat, s2_load;
  logic                          s1_vld_q, s2_vld_q;
  logic [rgbnv_pkg::PIX_W-1:0]   s1_r_q, s1_g_q, s1_b_q;
  logic                          s1_cv_q, cv_in;
  logic [rgbnv_pkg::PIX_W-1:0]   luma_d, first_d, second_d;
  logic [rgbnv_pkg::PIX_W-1:0]   luma_q, first_q, second_q;
  logic                          cv_q;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.studio_swing <= 1'b0;
      cfg_q.cr_first     <= 1'b0;
      cfg_q.blue_first   <= 1'b0;
      cfg_q.line_width   <= rgbnv_pkg::LW_W'(rgbnv_pkg::LINE_WIDTH_RST);
    end else if (cfg_we_i) begin
      unique case (rgbnv_pkg::cfg_idx_e'(cfg_idx_i))
        rgbnv_pkg::CFG_STUDIO_SWING: cfg_q.studio_swing <= cfg_data_i[0];
        rgbnv_pkg::CFG_CR_FIRST:     cfg_q.cr_first     <= cfg_data_i[0];
        rgbnv_pkg::CFG_BLUE_FIRST:   cfg_q.blue_first   <= cfg_data_i[0];
        rgbnv_pkg::CFG_LINE_WIDTH:   cfg_q.line_width   <= cfg_data_i[rgbnv_pkg::LW_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  assign s2_load = !s2_vld_q || ready_i;
  assign ready_o = !s1_vld_q || s2_load;
  assign in_beat = valid_i && ready_o;

  rgbnv_pos #(
    .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
  ) u_pos (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (in_beat),
    .frame_start_i  (frame_start_i),
    .line_width_i   (cfg_q.line_width),
    .chroma_valid_o (cv_in)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (ready_o) begin
      s1_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      s1_r_q  <= cfg_q.blue_first ? chan_c_i : chan_a_i;
      s1_g_q  <= chan_g_i;
      s1_b_q  <= cfg_q.blue_first ? chan_a_i : chan_c_i;
      s1_cv_q <= cv_in;
    end
  end

  rgbnv_csc u_csc (
    .studio_swing_i  (cfg_q.studio_swing),
    .cr_first_i      (cfg_q.cr_first),
    .chroma_valid_i  (s1_cv_q),
    .red_i           (s1_r_q),
    .green_i         (s1_g_q),
    .blue_i          (s1_b_q),
    .luma_o          (luma_d),
    .chroma_first_o  (first_d),
    .chroma_second_o (second_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (s2_load) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load && s1_vld_q) begin
      luma_q   <= luma_d;
      cv_q     <= s1_cv_q;
      first_q  <= first_d;
      second_q <= second_d;
    end
  end

  assign valid_o         = s2_vld_q;
  assign luma_o          = luma_q;
  assign chroma_valid_o  = cv_q;
  assign chroma_first_o  = first_q;
  assign chroma_second_o = second_q;

endmodule

`default_nettype wire

FILE: src/rgbnv_checker.sv
// Port-level checker for the RGB to NV12 converter, bound to the top level.
`default_nettype none

module rgbnv_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                ready_o,
  input wire logic                                valid_o,
  input wire logic                                ready_i,
  input wire logic [rgbnv_pkg::PIX_W-1:0]         luma_o,
  input wire logic                                chroma_valid_o,
  input wire logic [rgbnv_pkg::PIX_W-1:0]         chroma_first_o,
  input wire logic [rgbnv_pkg::PIX_W-1:0]         chroma_second_o
);

  // input only backs up when a result beat is held
  a_stall_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ready_o |-> valid_o)
    else $error("input stalled with no result pending");

  // pixels without chroma carry zero chroma bytes
  a_chroma_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !chroma_valid_o) |-> (chroma_first_o == '0 && chroma_second_o == '0))
    else $error("chroma bytes not zero on luma-only beat");

  // nothing in flight straight out of reset
  a_empty_after_reset: assert property (@(posedge clk_i)
    (rst_ni && !$past(rst_ni)) |-> !valid_o)
    else $error("result beat right after reset");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !ready_i) |=> (valid_o && $stable(luma_o) && $stable(chroma_valid_o)
      && $stable(chroma_first_o) && $stable(chroma_second_o)))
    else $error("stalled result beat changed");

endmodule

bind rgb_to_nv12_integer_converter rgbnv_checker u_rgbnv_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the RGB to NV12 converter: directed, stall and random traffic.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned WIDTH_CAP = 4096;

  typedef struct packed {
    logic [rgbnv_pkg::PIX_W-1:0] chan_a;
    logic [rgbnv_pkg::PIX_W-1:0] chan_g;
    logic [rgbnv_pkg::PIX_W-1:0] chan_c;
    logic                        frame_start;
  } rgb_pixel_t;

  typedef struct packed {
    logic [rgbnv_pkg::PIX_W-1:0] luma;
    logic                        chroma_valid;
    logic [rgbnv_pkg::PIX_W-1:0] chroma_first;
    logic [rgbnv_pkg::PIX_W-1:0] chroma_second;
  } nv_pixel_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             cfg_we_i = 1'b0;
  rgbnv_pkg::cfg_idx_e              cfg_idx_i = rgbnv_pkg::CFG_STUDIO_SWING;
  logic [rgbnv_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                             valid_i = 1'b0;
  logic                             ready_o;
  logic [rgbnv_pkg::PIX_W-1:0]      chan_a_i = '0;
  logic [rgbnv_pkg::PIX_W-1:0]      chan_g_i = '0;
  logic [rgbnv_pkg::PIX_W-1:0]      chan_c_i = '0;
  logic                             frame_start_i = 1'b0;
  logic                             valid_o;
  logic                             ready_i = 1'b0;
  logic [rgbnv_pkg::PIX_W-1:0]      luma_o;
  logic                             chroma_valid_o;
  logic [rgbnv_pkg::PIX_W-1:0]      chroma_first_o;
  logic [rgbnv_pkg::PIX_W-1:0]      chroma_second_o;

  rgb_to_nv12_integer_converter dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .valid_i         (valid_i),
    .ready_o         (ready_o),
    .chan_a_i        (chan_a_i),
    .chan_g_i        (chan_g_i),
    .chan_c_i        (chan_c_i),
    .frame_start_i   (frame_start_i),
    .valid_o         (valid_o),
    .ready_i         (ready_i),
    .luma_o          (luma_o),
    .chroma_valid_o  (chroma_valid_o),
    .chroma_first_o  (chroma_first_o),
    .chroma_second_o (chroma_second_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // converter settings and raster position as the block should hold them
  logic                             studio_q;
  logic                             cr_first_q;
  logic                             blue_first_q;
  logic [rgbnv_pkg::CFG_DATA_W-1:0] line_width_q;
  int                               col_pos;
  logic                             on_odd_row;

  nv_pixel_t pending_pixels[$];

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int stall_len = 0;
  int stall_tag = 0;
  int stall_seen = 0;
  int stall_left = 0;
  int errors = 0;
  int n_checked = 0;
  int n_chroma = 0;
  int n_writes = 0;

  function automatic logic [rgbnv_pkg::PIX_W-1:0] scale_clamp(input int acc, input int ofs);
    int v;
    v = ((acc + 128) >>> 8) + ofs;
    if (v < 0) return '0;
    if (v > 255) return '1;
    return v[rgbnv_pkg::PIX_W-1:0];
  endfunction

  function automatic int effective_width(input logic [rgbnv_pkg::CFG_DATA_W-1:0] w);
    if (w < rgbnv_pkg::LINE_WIDTH_MIN) return rgbnv_pkg::LINE_WIDTH_MIN;
    if (w > WIDTH_CAP) return WIDTH_CAP;
    return int'(w);
  endfunction

  function automatic nv_pixel_t convert_pixel(input rgb_pixel_t px);
    nv_pixel_t                   res;
    int                          r;
    int                          g;
    int                          b;
    int                          w;
    logic [rgbnv_pkg::PIX_W-1:0] y;
    logic [rgbnv_pkg::PIX_W-1:0] cb;
    logic [rgbnv_pkg::PIX_W-1:0] cr;
    r = blue_first_q ? int'(px.chan_c) : int'(px.chan_a);
    g = int'(px.chan_g);
    b = blue_first_q ? int'(px.chan_a) : int'(px.chan_c);
    w = effective_width(line_width_q);
    if (px.frame_start) begin
      col_pos = 0;
      on_odd_row = 1'b0;
    end
    if (studio_q) begin
      y  = scale_clamp(66 * r + 129 * g + 25 * b, 16);
      cb = scale_clamp(-38 * r - 74 * g + 112 * b, 128);
      cr = scale_clamp(112 * r - 94 * g - 18 * b, 128);
    end else begin
      y  = scale_clamp(77 * r + 150 * g + 29 * b, 0);
      cb = scale_clamp(-43 * r - 84 * g + 127 * b, 128);
      cr = scale_clamp(127 * r - 106 * g - 21 * b, 128);
    end
    res.luma = y;
    res.chroma_valid = !on_odd_row && (col_pos % 2 == 0);
    res.chroma_first = '0;
    res.chroma_second = '0;
    if (res.chroma_valid) begin
      res.chroma_first = cr_first_q ? cr : cb;
      res.chroma_second = cr_first_q ? cb : cr;
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      on_odd_row = !on_odd_row;
    end else begin
      col_pos++;
    end
    return res;
  endfunction

  function automatic logic [rgbnv_pkg::PIX_W-1:0] rand_chan();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return rgbnv_pkg::PIX_W'($urandom);
    endcase
  endfunction

  // single-bit registers get random upper bits, which must be ignored
  function automatic logic [rgbnv_pkg::CFG_DATA_W-1:0] flag_word(input logic v);
    logic [rgbnv_pkg::CFG_DATA_W-1:0] w;
    w = rgbnv_pkg::CFG_DATA_W'($urandom);
    w[0] = v;
    return w;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    errors++;
    $display("mismatch at pixel %0d: %s got %0d expected %0d", n_checked, field, got, want);
  endtask

  task automatic write_reg(input rgbnv_pkg::cfg_idx_e idx,
                           input logic [rgbnv_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      rgbnv_pkg::CFG_STUDIO_SWING: studio_q = data[0];
      rgbnv_pkg::CFG_CR_FIRST:     cr_first_q = data[0];
      rgbnv_pkg::CFG_BLUE_FIRST:   blue_first_q = data[0];
      rgbnv_pkg::CFG_LINE_WIDTH:   line_width_q = data;
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic set_config(input logic studio, input logic crf, input logic bluef,
                            input logic [rgbnv_pkg::CFG_DATA_W-1:0] width);
    write_reg(rgbnv_pkg::CFG_STUDIO_SWING, flag_word(studio));
    write_reg(rgbnv_pkg::CFG_CR_FIRST, flag_word(crf));
    write_reg(rgbnv_pkg::CFG_BLUE_FIRST, flag_word(bluef));
    write_reg(rgbnv_pkg::CFG_LINE_WIDTH, width);
  endtask

  task automatic send_pixel(input rgb_pixel_t px);
    while ($urandom_range(99) < src_idle_pct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    chan_a_i <= px.chan_a;
    chan_g_i <= px.chan_g;
    chan_c_i <= px.chan_c;
    frame_start_i <= px.frame_start;
    @(posedge clk_i);
    while (!ready_o) @(posedge clk_i);
    pending_pixels.push_back(convert_pixel(px));
  endtask

  // sender stops until every expected beat is out; block is then idle
  task automatic drain();
    valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic send_corners(input int first_start);
    rgb_pixel_t px;
    for (int k = 0; k < 8; k++) begin
      px.chan_a = k[0] ? '1 : '0;
      px.chan_g = k[1] ? '1 : '0;
      px.chan_c = k[2] ? '1 : '0;
      px.frame_start = (k == first_start);
      send_pixel(px);
    end
  endtask

  task automatic test_colour_extremes();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    send_corners(0);
    drain();
    set_config(1'b1, 1'b1, 1'b1, 13'd0);
    send_corners(0);
    drain();
  endtask

  task automatic test_register_extremes();
    rgb_pixel_t px;
    set_config(1'b0, 1'b1, 1'b0, 13'h1FFF);
    for (int k = 0; k < 5; k++) begin
      px = {8'h80, 8'h01, 8'hFE, k == 0};
      send_pixel(px);
    end
    drain();
    set_config(1'b1, 1'b0, 1'b1, 13'd17);
    for (int k = 0; k < 5; k++) begin
      px = {8'h7F, 8'hFE, 8'h01, 1'b0};
      send_pixel(px);
    end
    drain();
  endtask

  task automatic test_output_stall();
    rgb_pixel_t px;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    set_config(1'b0, 1'b0, 1'b0, 13'd16);
    stall_len = 80;
    stall_tag++;
    for (int k = 0; k < 30; k++) begin
      px = {rand_chan(), rand_chan(), rand_chan(), k == 0};
      send_pixel(px);
    end
    drain();
  endtask

  task automatic run_random_frames(input int n_items);
    int                               done_items;
    int                               n_pix;
    int                               eff_w;
    logic                             fresh;
    logic [rgbnv_pkg::CFG_DATA_W-1:0] w;
    rgb_pixel_t                       px;
    done_items = 0;
    while (done_items < n_items) begin
      drain();
      case ($urandom_range(9))
        6:       w = rgbnv_pkg::CFG_DATA_W'(17 + 2 * $urandom_range(15));
        7:       w = rgbnv_pkg::CFG_DATA_W'(WIDTH_CAP);
        8:       w = rgbnv_pkg::CFG_DATA_W'($urandom_range(15));
        9:       w = rgbnv_pkg::CFG_DATA_W'($urandom_range(8191, WIDTH_CAP + 1));
        default: w = rgbnv_pkg::CFG_DATA_W'(16 + 2 * $urandom_range(16));
      endcase
      set_config(1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)), w);
      eff_w = effective_width(w);
      if (eff_w > 64) n_pix = $urandom_range(70, 20);
      else n_pix = eff_w * $urandom_range(4, 1) + $urandom_range(eff_w - 1);
      // a quarter of the segments carry on from the old position
      fresh = ($urandom_range(3) != 0);
      for (int i = 0; i < n_pix; i++) begin
        px.chan_a = rand_chan();
        px.chan_g = rand_chan();
        px.chan_c = rand_chan();
        px.frame_start = (i == 0 && fresh) || ($urandom_range(49) == 0);
        send_pixel(px);
      end
      done_items += n_pix;
    end
  endtask

  task automatic test_random_traffic();
    src_idle_pct = 31;
    snk_idle_pct = 78;
    run_random_frames(390);
    src_idle_pct = 78;
    snk_idle_pct = 31;
    run_random_frames(390);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_random_frames(390);
    drain();
  endtask

  always @(posedge clk_i) begin
    if (stall_tag != stall_seen) begin
      stall_seen = stall_tag;
      stall_left = stall_len;
    end
    if (stall_left > 0) begin
      stall_left--;
      ready_i <= 1'b0;
    end else begin
      ready_i <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_beat
    nv_pixel_t want;
    if (rst_ni && valid_o && ready_i) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("beat with nothing pending, luma", luma_o, 0);
      end else begin
        want = pending_pixels.pop_front();
        if (luma_o !== want.luma) report_mismatch("luma", luma_o, want.luma);
        if (chroma_valid_o !== want.chroma_valid)
          report_mismatch("chroma_valid", chroma_valid_o, want.chroma_valid);
        if (chroma_first_o !== want.chroma_first)
          report_mismatch("chroma_first", chroma_first_o, want.chroma_first);
        if (chroma_second_o !== want.chroma_second)
          report_mismatch("chroma_second", chroma_second_o, want.chroma_second);
        n_checked++;
        if (want.chroma_valid) n_chroma++;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    studio_q = 1'b0;
    cr_first_q = 1'b0;
    blue_first_q = 1'b0;
    line_width_q = rgbnv_pkg::CFG_DATA_W'(rgbnv_pkg::LINE_WIDTH_RST);
    col_pos = 0;
    on_odd_row = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_colour_extremes();
    test_register_extremes();
    test_output_stall();
    test_random_traffic();
    repeat (10) @(posedge clk_i);
    if (pending_pixels.size() != 0)
      report_mismatch("beats never delivered", 0, pending_pixels.size());
    $display("checked %0d pixels, %0d carrying chroma, over %0d register writes",
             n_checked, n_chroma, n_writes);
    $display("covered both swings, NV12/NV21, RGB/BGR, odd and out-of-range widths, stalls");
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
